/* hw/rtl/gmr_pkg.sv */
// ----------------------------------------------------------------------------
// gmr_pkg: shared types and constants for the grid maze reachability block
// Grid geometry, cell class codes, neighbor directions and the control and
// status bundles between the sequencer and the work stack.
// ----------------------------------------------------------------------------
package gmr_pkg;

   // Grid geometry. The row and column fields are six bits wide.
   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int ROW_W    = 6;
   localparam int COL_W    = 6;
   localparam int CNT_W    = 7;
   localparam int CELLS    = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W   = $clog2(CELLS);

   // Visited marks carry a search tag, so the map needs no clearing between
   // searches until the tag wraps.
   localparam int EPOCH_W = 4;
   localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COL_COUNT = 2'd1;

   // Request actions.
   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_SEARCH = 1'b1;

   // Cell classes. Codes two and three both count as class other.
   localparam logic [1:0] KIND_WALL    = 2'd0;
   localparam logic [1:0] KIND_PASSAGE = 2'd1;

   typedef enum logic [1:0] {
      DIR_DOWN,
      DIR_UP,
      DIR_RIGHT,
      DIR_LEFT
   } dir_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } coord_type;

   typedef struct packed {
      coord_type pos;
      logic      in_grid;
   } nbr_type;

   typedef struct packed {
      logic      restart;
      logic      push;
      logic      pop;
      coord_type data;
   } stack_ctl_type;

   typedef struct packed {
      logic      empty;
      coord_type data;
   } stack_sts_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input coord_type pos);
      cell_addr = ADDR_W'(ADDR_W'(pos.row) * ADDR_W'(MAX_COLS) + ADDR_W'(pos.col));
   endfunction

endpackage

/* hw/rtl/gmr_nbr_unit.sv */
// ----------------------------------------------------------------------------
// gmr_nbr_unit: neighbor step and bounds check
// Steps one cell in the chosen direction and tells whether the neighbor lies
// inside the rows and columns in use. Shared by every neighbor visit.
// ----------------------------------------------------------------------------
module gmr_nbr_unit (
   input  gmr_pkg::coord_type          cur,
   input  gmr_pkg::dir_type            dir,
   input  logic [gmr_pkg::CNT_W-1:0]   rows_lim,
   input  logic [gmr_pkg::CNT_W-1:0]   cols_lim,
   output gmr_pkg::nbr_type            nbr
);

   logic [gmr_pkg::CNT_W-1:0] row_up;
   logic [gmr_pkg::CNT_W-1:0] col_up;

   assign row_up = gmr_pkg::CNT_W'(cur.row) + gmr_pkg::CNT_W'(1);
   assign col_up = gmr_pkg::CNT_W'(cur.col) + gmr_pkg::CNT_W'(1);

   always_comb begin
      nbr.pos = cur;
      nbr.in_grid = 1'b0;
      unique case (dir)
         gmr_pkg::DIR_DOWN: begin
            nbr.pos.row = row_up[gmr_pkg::ROW_W-1:0];
            nbr.in_grid = row_up < rows_lim;
         end
         gmr_pkg::DIR_UP: begin
            nbr.pos.row = cur.row - gmr_pkg::ROW_W'(1);
            nbr.in_grid = cur.row != '0;
         end
         gmr_pkg::DIR_RIGHT: begin
            nbr.pos.col = col_up[gmr_pkg::COL_W-1:0];
            nbr.in_grid = col_up < cols_lim;
         end
         gmr_pkg::DIR_LEFT: begin
            nbr.pos.col = cur.col - gmr_pkg::COL_W'(1);
            nbr.in_grid = cur.col != '0;
         end
         default: begin
            nbr.in_grid = 1'b0;
         end
      endcase
   end

endmodule

/* hw/rtl/gmr_stack.sv */
// ----------------------------------------------------------------------------
// gmr_stack: work stack of cells still to expand
// One-port-write, one-port-read memory with a top pointer. A pop registers
// the top entry, which shows on the data output in the next cycle.
// ----------------------------------------------------------------------------
module gmr_stack (
   input  logic                   clock,
   input  logic                   reset,
   input  gmr_pkg::stack_ctl_type ctl,
   output gmr_pkg::stack_sts_type sts
);

   gmr_pkg::coord_type stack_mem [gmr_pkg::CELLS];

   logic [gmr_pkg::ADDR_W:0]   top_ff;
   logic [gmr_pkg::ADDR_W:0]   top_in;
   logic [gmr_pkg::ADDR_W:0]   top_dec;
   logic [gmr_pkg::ADDR_W-1:0] wr_idx;
   gmr_pkg::coord_type         rd_ff;

   assign top_dec = top_ff - (gmr_pkg::ADDR_W + 1)'(1);
   assign wr_idx  = ctl.restart ? '0 : top_ff[gmr_pkg::ADDR_W-1:0];

   always_comb begin
      top_in = top_ff;
      priority if (ctl.restart) begin
         top_in = (gmr_pkg::ADDR_W + 1)'(1);
      end else if (ctl.push) begin
         top_in = top_ff + (gmr_pkg::ADDR_W + 1)'(1);
      end else if (ctl.pop) begin
         top_in = top_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
      end else begin
         top_ff <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.restart || ctl.push) begin
         stack_mem[wr_idx] <= ctl.data;
      end
      if (ctl.pop) begin
         rd_ff <= stack_mem[top_dec[gmr_pkg::ADDR_W-1:0]];
      end
   end

   assign sts.empty = top_ff == '0;
   assign sts.data  = rd_ff;

endmodule

/* hw/rtl/grid_maze_reachability.sv */
// ----------------------------------------------------------------------------
// grid_maze_reachability: flood-fill reachability search over a loaded grid
// Holds a 64 x 64 grid of cells and answers whether a cell of class other
// can be reached from a start cell through passage cells.
// ----------------------------------------------------------------------------
// A write beat (action 0) stores one cell class; it produces no response
// beat. A search beat (action 1) names a start cell and produces exactly one
// response beat carrying found. The search is a flood fill driven by a small
// sequencer around one shared neighbor step and bounds unit. Each cell taken
// off the work stack goes through a pop, a load and four neighbor steps, plus
// a check for every in-bounds neighbor. When the work stack runs empty, the
// pop state moves on to the response state, which raises the response beat;
// a check that sees a cell of class other moves there directly and ends the
// search early. A start cell outside the rows and columns in use moves there
// straight from the idle state. req_ready comes back as the response beat is
// raised, unless a sweep follows; while an earlier response beat is still
// waiting to be taken, the block holds its finished search. The visited map
// stores a four-bit search tag per cell, so it is swept clean only when the
// tag wraps: a sweep of the whole map follows reset and every fifteenth
// search whose start cell lies inside the grid, and req_ready stays low
// during it. Configuration writes are accepted in every cycle and should be
// issued only while no search is in flight. Grid cells read by a search must
// have been written since reset.
// ----------------------------------------------------------------------------
module grid_maze_reachability (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [gmr_pkg::ROW_W-1:0]     req_row,
   input  logic [gmr_pkg::COL_W-1:0]     req_col,
   input  logic [1:0]                    req_cell_kind,
   // Response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   // Configuration channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gmr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gmr_pkg::CNT_W-1:0]     csr_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_POP,
      ST_LOAD,
      ST_ISSUE,
      ST_CHECK,
      ST_RESP
   } state_type;

   localparam logic [gmr_pkg::CNT_W-1:0]  ROW_LIMIT = gmr_pkg::CNT_W'(gmr_pkg::MAX_ROWS);
   localparam logic [gmr_pkg::CNT_W-1:0]  COL_LIMIT = gmr_pkg::CNT_W'(gmr_pkg::MAX_COLS);
   localparam logic [gmr_pkg::ADDR_W-1:0] LAST_ADDR = gmr_pkg::ADDR_W'(gmr_pkg::CELLS - 1);

   // Sequencer and registered outputs.
   state_type                       state_ff;
   logic [gmr_pkg::CNT_W-1:0]       row_count_ff;
   logic [gmr_pkg::CNT_W-1:0]       col_count_ff;
   logic [gmr_pkg::EPOCH_W-1:0]     epoch_ff;
   logic [gmr_pkg::ADDR_W-1:0]      clr_addr_ff;
   gmr_pkg::coord_type              cur_ff;
   gmr_pkg::coord_type              start_ff;
   gmr_pkg::coord_type              nbr_ff;
   gmr_pkg::dir_type                dir_ff;
   logic                            found_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_found_ff;

   // Grid and visited memories with registered read data.
   logic [1:0]                      cell_mem [gmr_pkg::CELLS];
   logic [gmr_pkg::EPOCH_W-1:0]     vis_mem  [gmr_pkg::CELLS];
   logic [1:0]                      cell_rd_ff;
   logic [gmr_pkg::EPOCH_W-1:0]     vis_rd_ff;

   logic [gmr_pkg::CNT_W-1:0]       rows_lim;
   logic [gmr_pkg::CNT_W-1:0]       cols_lim;
   gmr_pkg::coord_type              req_pos;
   gmr_pkg::nbr_type                nbr;
   gmr_pkg::stack_ctl_type          stk_ctl;
   gmr_pkg::stack_sts_type          stk_sts;
   logic                            req_fire;
   logic                            load_fire;
   logic                            search_fire;
   logic                            start_inside;
   logic                            dir_last;
   logic                            push_now;
   logic                            hit_now;
   logic                            rsp_free;
   logic                            vis_we;
   logic [gmr_pkg::ADDR_W-1:0]      vis_wr_addr;
   logic [gmr_pkg::EPOCH_W-1:0]     vis_wr_data;
   logic [gmr_pkg::EPOCH_W-1:0]     epoch_next;

   // Rows and columns in use, capped at the grid size. A zero count leaves
   // no cell inside, so every search then answers found 0.
   assign rows_lim = (row_count_ff < ROW_LIMIT) ? row_count_ff : ROW_LIMIT;
   assign cols_lim = (col_count_ff < COL_LIMIT) ? col_count_ff : COL_LIMIT;

   assign req_pos.row  = req_row;
   assign req_pos.col  = req_col;
   assign req_ready    = state_ff == ST_IDLE;
   assign csr_ready    = 1'b1;
   assign req_fire     = req_valid && req_ready;
   assign load_fire    = req_fire && (req_action == gmr_pkg::ACT_WRITE);
   assign search_fire  = req_fire && (req_action == gmr_pkg::ACT_SEARCH);
   assign start_inside = (gmr_pkg::CNT_W'(req_row) < rows_lim)
                      && (gmr_pkg::CNT_W'(req_col) < cols_lim);
   assign epoch_next   = epoch_ff + gmr_pkg::EPOCH_W'(1);
   assign dir_last     = dir_ff == gmr_pkg::DIR_LEFT;
   assign rsp_free     = !rsp_valid_ff || rsp_ready;

   // The neighbor under test: a passage not yet tagged by this search is
   // marked and pushed; a cell of class other ends the search unless it is
   // the start cell itself.
   assign push_now = (state_ff == ST_CHECK) && (cell_rd_ff == gmr_pkg::KIND_PASSAGE)
                  && (vis_rd_ff != epoch_ff);
   assign hit_now  = (state_ff == ST_CHECK) && (cell_rd_ff != gmr_pkg::KIND_WALL)
                  && (cell_rd_ff != gmr_pkg::KIND_PASSAGE) && (nbr_ff != start_ff);

   gmr_nbr_unit u_nbr (
      .cur      (cur_ff),
      .dir      (dir_ff),
      .rows_lim (rows_lim),
      .cols_lim (cols_lim),
      .nbr      (nbr)
   );

   always_comb begin
      stk_ctl.restart = search_fire && start_inside;
      stk_ctl.push    = push_now;
      stk_ctl.pop     = (state_ff == ST_POP) && !stk_sts.empty;
      stk_ctl.data    = stk_ctl.restart ? req_pos : nbr_ff;
   end

   gmr_stack u_stack (
      .clock (clock),
      .reset (reset),
      .ctl   (stk_ctl),
      .sts   (stk_sts)
   );

   // Visited map write port: the sweep, the start cell, or a pushed passage.
   always_comb begin
      vis_we      = 1'b0;
      vis_wr_addr = gmr_pkg::cell_addr(nbr_ff);
      vis_wr_data = epoch_ff;
      priority if (state_ff == ST_CLEAR) begin
         vis_we      = 1'b1;
         vis_wr_addr = clr_addr_ff;
         vis_wr_data = '0;
      end else if (search_fire && start_inside) begin
         vis_we      = 1'b1;
         vis_wr_addr = gmr_pkg::cell_addr(req_pos);
         vis_wr_data = epoch_next;
      end else if (push_now) begin
         vis_we      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_fire) begin
         cell_mem[gmr_pkg::cell_addr(req_pos)] <= req_cell_kind;
      end
      cell_rd_ff <= cell_mem[gmr_pkg::cell_addr(nbr.pos)];
   end

   always_ff @(posedge clock) begin
      if (vis_we) begin
         vis_mem[vis_wr_addr] <= vis_wr_data;
      end
      vis_rd_ff <= vis_mem[gmr_pkg::cell_addr(nbr.pos)];
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_count_ff <= ROW_LIMIT;
         col_count_ff <= COL_LIMIT;
         epoch_ff     <= '0;
         clr_addr_ff  <= '0;
         dir_ff       <= gmr_pkg::DIR_DOWN;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_found_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            priority if (csr_index == gmr_pkg::REG_ROW_COUNT) begin
               row_count_ff <= csr_data;
            end else if (csr_index == gmr_pkg::REG_COL_COUNT) begin
               col_count_ff <= csr_data;
            end
         end

         // In the response state the new beat takes the place of the old one.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_RESP)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + gmr_pkg::ADDR_W'(1);
               if (clr_addr_ff == LAST_ADDR) begin
                  epoch_ff <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (search_fire) begin
                  if (start_inside) begin
                     epoch_ff <= epoch_next;
                     start_ff <= req_pos;
                     state_ff <= ST_POP;
                  end else begin
                     found_ff <= 1'b0;
                     state_ff <= ST_RESP;
                  end
               end
            end
            ST_POP: begin
               if (stk_sts.empty) begin
                  found_ff <= 1'b0;
                  state_ff <= ST_RESP;
               end else begin
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               cur_ff   <= stk_sts.data;
               dir_ff   <= gmr_pkg::DIR_DOWN;
               state_ff <= ST_ISSUE;
            end
            ST_ISSUE: begin
               if (nbr.in_grid) begin
                  nbr_ff   <= nbr.pos;
                  state_ff <= ST_CHECK;
               end else if (dir_last) begin
                  state_ff <= ST_POP;
               end else begin
                  dir_ff <= gmr_pkg::dir_type'(dir_ff + 2'd1);
               end
            end
            ST_CHECK: begin
               if (hit_now) begin
                  found_ff <= 1'b1;
                  state_ff <= ST_RESP;
               end else if (dir_last) begin
                  state_ff <= ST_POP;
               end else begin
                  dir_ff   <= gmr_pkg::dir_type'(dir_ff + 2'd1);
                  state_ff <= ST_ISSUE;
               end
            end
            ST_RESP: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_found_ff <= found_ff;
                  if (epoch_ff == gmr_pkg::EPOCH_MAX) begin
                     clr_addr_ff <= '0;
                     state_ff    <= ST_CLEAR;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

endmodule

/* hw/rtl/gmr_checker.sv */
// ----------------------------------------------------------------------------
// gmr_checker: port-level checks for the grid maze reachability block
// Watches the request and response ports over time.
// ----------------------------------------------------------------------------
module gmr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_action,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_found
);

   // A stalled response beat holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found))
      else $error("response beat changed while stalled");

   // An accepted search beat always drops req_ready in the next cycle.
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == gmr_pkg::ACT_SEARCH) |=> !req_ready)
      else $error("request accepted right after a search beat");

   // A cell write never stalls the request channel.
   a_write_flow: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == gmr_pkg::ACT_WRITE) |=> req_ready)
      else $error("cell write stalled the request channel");

   // A response appears only as a search finishes, while requests are held off.
   a_rsp_from_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response beat without a search in flight");

endmodule

bind grid_maze_reachability gmr_checker u_gmr_checker (.*);

/* dv/grid_maze_reachability_test.sv */
// ----------------------------------------------------------------------------
// grid_maze_reachability_test: self-checking bench for the maze search block
// A short table of directed beats covers empty grids, counts above the
// store, unknown register indexes, start cells outside the grid, the start
// cell that is itself of class other, and kind code three. After that, grids
// of random shape are loaded cell by cell and searched at random. Every
// response beat is checked against a flood-fill predictor or a typed answer.
// ----------------------------------------------------------------------------
module grid_maze_reachability_test;
   timeunit 1ns;
   timeprecision 1ps;
   import gmr_pkg::*;

   // Kind codes beyond wall and passage. Both count as class other.
   localparam logic [1:0] KIND_OTHER = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   // Register indexes that the block does not decode and must ignore.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 2'd3;

   localparam int ITEM_TARGET   = 1600;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 32;
   // Worst case is far below this: about 500 searches over at most 128 cells,
   // 35 visited-map sweeps, and idle gaps on both sides.
   localparam int CYCLE_LIMIT   = 3_000_000;

   // The directed part is a table. A row either writes a register or sends
   // one request beat. For a few rows the answer is obvious from the rules
   // (empty grid, start outside the grid), so it is typed into the row.
   // Every other search row is checked against the predictor.
   typedef enum logic [1:0] {
      STEP_CSR,
      STEP_ITEM,
      STEP_ITEM_TYPED
   } step_type;

   typedef struct packed {
      step_type               step;
      logic [CSR_IDX_W-1:0]   index;
      logic [CNT_W-1:0]       data;
      logic                   action;
      logic [ROW_W-1:0]       row;
      logic [COL_W-1:0]       col;
      logic [1:0]             cell_kind;
      logic                   want;
   } plan_row_type;

   localparam int PLAN_LEN = 22;
   localparam plan_row_type OPENING_PLAN [PLAN_LEN] = '{
      // A row count of zero leaves the grid empty, so every search misses.
      '{STEP_CSR,        REG_ROW_COUNT, 7'd0,   ACT_WRITE,  6'd0,  6'd0,  KIND_WALL,    1'b0},
      '{STEP_ITEM_TYPED, REG_ROW_COUNT, 7'd0,   ACT_SEARCH, 6'd0,  6'd0,  KIND_WALL,    1'b0},
      // A row count above the store is clipped, but zero columns is still empty.
      '{STEP_CSR,        REG_ROW_COUNT, 7'd127, ACT_WRITE,  6'd0,  6'd0,  KIND_WALL,    1'b0},
      '{STEP_CSR,        REG_COL_COUNT, 7'd0,   ACT_WRITE,  6'd0,  6'd0,  KIND_WALL,    1'b0},
      '{STEP_ITEM_TYPED, REG_ROW_COUNT, 7'd0,   ACT_SEARCH, 6'd63, 6'd63, KIND_WALL,    1'b0},
      // A one-by-three strip. The writes to unknown indexes must not touch it.
      '{STEP_CSR,        REG_COL_COUNT, 7'd3,   ACT_WRITE,  6'd0,  6'd0,  KIND_WALL,    1'b0},
      '{STEP_CSR,        REG_ROW_COUNT, 7'd1,   ACT_WRITE,  6'd0,  6'd0,  KIND_WALL,    1'b0},
      '{STEP_CSR,        REG_SPARE_A,   7'd127, ACT_WRITE,  6'd0,  6'd0,  KIND_WALL,    1'b0},
      '{STEP_CSR,        REG_SPARE_B,   7'd0,   ACT_WRITE,  6'd0,  6'd0,  KIND_WALL,    1'b0},
      '{STEP_ITEM,       REG_ROW_COUNT, 7'd0,   ACT_WRITE,  6'd0,  6'd0,  KIND_OTHER,   1'b0},
      '{STEP_ITEM,       REG_ROW_COUNT, 7'd0,   ACT_WRITE,  6'd0,  6'd1,  KIND_PASSAGE, 1'b0},
      '{STEP_ITEM,       REG_ROW_COUNT, 7'd0,   ACT_WRITE,  6'd0,  6'd2,  KIND_SPARE,   1'b0},
      // The start is of class other itself. Only the far end may count.
      '{STEP_ITEM,       REG_ROW_COUNT, 7'd0,   ACT_SEARCH, 6'd0,  6'd0,  KIND_WALL,    1'b0},
      '{STEP_ITEM,       REG_ROW_COUNT, 7'd0,   ACT_SEARCH, 6'd0,  6'd1,  KIND_WALL,    1'b0},
      // With the far end walled off, the start is the only cell of class other.
      '{STEP_ITEM,       REG_ROW_COUNT, 7'd0,   ACT_WRITE,  6'd0,  6'd2,  KIND_WALL,    1'b0},
      '{STEP_ITEM,       REG_ROW_COUNT, 7'd0,   ACT_SEARCH, 6'd0,  6'd0,  KIND_WALL,    1'b0},
      '{STEP_ITEM,       REG_ROW_COUNT, 7'd0,   ACT_SEARCH, 6'd0,  6'd2,  KIND_WALL,    1'b0},
      // Start cells beyond the columns or rows in use.
      '{STEP_ITEM_TYPED, REG_ROW_COUNT, 7'd0,   ACT_SEARCH, 6'd0,  6'd63, KIND_WALL,    1'b0},
      '{STEP_ITEM_TYPED, REG_ROW_COUNT, 7'd0,   ACT_SEARCH, 6'd63, 6'd0,  KIND_WALL,    1'b0},
      // The far corner of the store, then a start that is a walled-in wall.
      '{STEP_ITEM,       REG_ROW_COUNT, 7'd0,   ACT_WRITE,  6'd63, 6'd63, KIND_SPARE,   1'b0},
      '{STEP_ITEM,       REG_ROW_COUNT, 7'd0,   ACT_WRITE,  6'd0,  6'd1,  KIND_WALL,    1'b0},
      '{STEP_ITEM,       REG_ROW_COUNT, 7'd0,   ACT_SEARCH, 6'd0,  6'd2,  KIND_WALL,    1'b0}
   };

   // Clock, reset and every input of the block start at known values.
   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_ready;
   logic                 req_action    = ACT_WRITE;
   logic [ROW_W-1:0]     req_row       = '0;
   logic [COL_W-1:0]     req_col       = '0;
   logic [1:0]           req_cell_kind = KIND_WALL;
   logic                 rsp_valid;
   logic                 rsp_ready     = 1'b0;
   logic                 rsp_found;
   logic                 csr_valid     = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index     = REG_ROW_COUNT;
   logic [CNT_W-1:0]     csr_data      = '0;

   // Predictor state: the grid as the block should hold it, and the two
   // counts. The seen map and the fill stack are scratch for one search.
   logic [1:0]       cell_kinds [CELLS];
   logic [CNT_W-1:0] row_limit = CNT_W'(MAX_ROWS);
   logic [CNT_W-1:0] col_limit = CNT_W'(MAX_COLS);
   bit               seen_map   [CELLS];
   int               fill_stack [CELLS];

   // Expected found flags, oldest first, one per accepted search beat.
   bit found_due [$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  items_sent     = 0;
   int  writes_sent    = 0;
   int  searches_sent  = 0;
   int  answers_seen   = 0;
   int  hits_seen      = 0;
   int  shape_count    = 0;
   // When set, neither side idles, so the block runs at its full rate.
   bit  calm           = 1'b0;

   grid_maze_reachability DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_cell_kind (req_cell_kind),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_found     (rsp_found),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #5 clock = ~clock;

   // Hard stop in case a handshake never completes.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d answers still due.",
                  cycle_count, found_due.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("ERROR at %0t: %s", $time, msg);
   endtask

   // Flood fill over passage cells from the start. The search succeeds as
   // soon as an in-bounds neighbor of class other turns up that is not the
   // start cell. Walls stop the fill; codes two and three are both other.
   function automatic bit predict_found(input logic [ROW_W-1:0] r,
                                        input logic [COL_W-1:0] c);
      int         rows;
      int         cols;
      int         start;
      int         top;
      int         cur;
      int         cur_r;
      int         cur_c;
      int         nr;
      int         nc;
      int         nidx;
      logic [1:0] kind;
      rows = (int'(row_limit) < MAX_ROWS) ? int'(row_limit) : MAX_ROWS;
      cols = (int'(col_limit) < MAX_COLS) ? int'(col_limit) : MAX_COLS;
      if (int'(r) >= rows || int'(c) >= cols)
         return 1'b0;
      foreach (seen_map[i])
         seen_map[i] = 1'b0;
      start = int'(r) * MAX_COLS + int'(c);
      seen_map[start] = 1'b1;
      fill_stack[0] = start;
      top = 1;
      while (top > 0) begin
         top--;
         cur   = fill_stack[top];
         cur_r = cur / MAX_COLS;
         cur_c = cur % MAX_COLS;
         for (int d = 0; d < 4; d++) begin
            case (dir_type'(d))
               DIR_DOWN: begin
                  nr = cur_r + 1;
                  nc = cur_c;
               end
               DIR_UP: begin
                  nr = cur_r - 1;
                  nc = cur_c;
               end
               DIR_RIGHT: begin
                  nr = cur_r;
                  nc = cur_c + 1;
               end
               default: begin
                  nr = cur_r;
                  nc = cur_c - 1;
               end
            endcase
            if (nr < 0 || nr >= rows || nc < 0 || nc >= cols)
               continue;
            nidx = nr * MAX_COLS + nc;
            kind = cell_kinds[nidx];
            if (kind == KIND_WALL)
               continue;
            if (kind == KIND_PASSAGE) begin
               if (!seen_map[nidx]) begin
                  seen_map[nidx] = 1'b1;
                  fill_stack[top] = nidx;
                  top++;
               end
            end else if (nidx != start) begin
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   // Mostly passages and walls, so that fills wander before they hit a goal.
   function automatic logic [1:0] draw_kind();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35)
         return KIND_WALL;
      if (roll < 90)
         return KIND_PASSAGE;
      if (roll < 96)
         return KIND_OTHER;
      return KIND_SPARE;
   endfunction

   // A full count of 64 is sometimes written as a larger value, which the
   // block must clip to the size of the store.
   function automatic logic [CNT_W-1:0] count_code(input int n);
      if (n == MAX_ROWS && $urandom_range(0, 1) == 1)
         return CNT_W'($urandom_range(MAX_ROWS + 1, 127));
      return CNT_W'(n);
   endfunction

   // Stops sending, waits until every search has been answered, and lets a
   // few more cycles pass so that a trailing cell write has landed.
   task automatic settle();
      req_valid <= 1'b0;
      while (found_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Registers are only written with nothing in flight.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CNT_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx == REG_ROW_COUNT)
         row_limit = value;
      else if (idx == REG_COL_COUNT)
         col_limit = value;
   endtask

   // Sends one request beat after a random gap. Valid is left high after the
   // beat is taken, so that a following beat with no gap keeps it high.
   // The prediction is made at acceptance, against the grid as it is then.
   task automatic send_beat(input logic act, input logic [ROW_W-1:0] r,
                            input logic [COL_W-1:0] c, input logic [1:0] kind,
                            input bit typed, input bit want);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_row       <= r;
      req_col       <= c;
      req_cell_kind <= kind;
      do @(posedge clock); while (req_ready !== 1'b1);
      items_sent++;
      if (act == ACT_WRITE) begin
         cell_kinds[int'(r) * MAX_COLS + int'(c)] = kind;
         writes_sent++;
      end else begin
         searches_sent++;
         found_due.push_back(typed ? want : predict_found(r, c));
      end
   endtask

   // One grid shape: set the counts, load every cell in use, then mix
   // searches with rewrites. Searches inside the grid only ever read cells
   // that the load has written.
   task automatic run_shape(input int rows, input int cols);
      int roll;
      int ops;
      if ($urandom_range(0, 1) == 1) begin
         write_register(REG_ROW_COUNT, count_code(rows));
         write_register(REG_COL_COUNT, count_code(cols));
      end else begin
         write_register(REG_COL_COUNT, count_code(cols));
         write_register(REG_ROW_COUNT, count_code(rows));
      end
      if ($urandom_range(0, 7) == 0)
         write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                        CNT_W'($urandom_range(0, 127)));
      calm = ($urandom_range(0, 3) == 0);
      for (int r = 0; r < rows; r++)
         for (int c = 0; c < cols; c++)
            send_beat(ACT_WRITE, ROW_W'(r), COL_W'(c), draw_kind(), 1'b0, 1'b0);
      ops = $urandom_range(6, 20);
      repeat (ops) begin
         roll = $urandom_range(0, 99);
         if (roll < 60)
            send_beat(ACT_SEARCH, ROW_W'($urandom_range(0, rows - 1)),
                      COL_W'($urandom_range(0, cols - 1)),
                      2'($urandom_range(0, 3)), 1'b0, 1'b0);
         else if (roll < 70)
            send_beat(ACT_SEARCH, ROW_W'($urandom_range(0, 63)),
                      COL_W'($urandom_range(0, 63)),
                      2'($urandom_range(0, 3)), 1'b0, 1'b0);
         else if (roll < 95)
            send_beat(ACT_WRITE, ROW_W'($urandom_range(0, rows - 1)),
                      COL_W'($urandom_range(0, cols - 1)), draw_kind(), 1'b0, 1'b0);
         else
            send_beat(ACT_WRITE, ROW_W'($urandom_range(0, 63)),
                      COL_W'($urandom_range(0, 63)),
                      2'($urandom_range(0, 3)), 1'b0, 1'b0);
         // Now and then the sender holds off until the block has answered all.
         if ($urandom_range(0, 49) == 0)
            settle();
      end
      shape_count++;
   endtask

   // Response side: stalls a random number of cycles before each beat, then
   // takes the beat and checks it against the oldest expected flag.
   initial begin : response_side
      int stall;
      bit due;
      forever begin
         stall = calm ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1 || reset);
         answers_seen++;
         if (rsp_found === 1'b1)
            hits_seen++;
         if (found_due.size() == 0) begin
            flag_error($sformatf("response beat %0d (found=%b) with no search waiting",
                                 answers_seen, rsp_found));
         end else begin
            due = found_due.pop_front();
            if (rsp_found !== due)
               flag_error($sformatf("response beat %0d: found expected %b, got %b",
                                    answers_seen, due, rsp_found));
         end
      end
   end

   // Stimulus: reset, the directed table, then random grid shapes. The first
   // two shapes are a single full-width row and a single full-height column,
   // so that every row and column bit is exercised; a few later shapes are
   // long and thin, most are small.
   initial begin : request_side
      plan_row_type entry;
      int           rows;
      int           cols;
      int           roll;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_LEN; i++) begin
         entry = OPENING_PLAN[i];
         case (entry.step)
            STEP_CSR: begin
               write_register(entry.index, entry.data);
            end
            STEP_ITEM: begin
               send_beat(entry.action, entry.row, entry.col, entry.cell_kind, 1'b0, 1'b0);
            end
            default: begin
               send_beat(entry.action, entry.row, entry.col, entry.cell_kind, 1'b1,
                         entry.want);
            end
         endcase
      end

      while (items_sent < ITEM_TARGET) begin
         if (shape_count == 0) begin
            rows = 1;
            cols = MAX_COLS;
         end else if (shape_count == 1) begin
            rows = MAX_ROWS;
            cols = 1;
         end else begin
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
               rows = $urandom_range(32, MAX_ROWS);
               cols = $urandom_range(1, 2);
            end else if (roll == 1) begin
               rows = $urandom_range(1, 2);
               cols = $urandom_range(32, MAX_COLS);
            end else begin
               rows = $urandom_range(1, 8);
               cols = $urandom_range(1, 8);
            end
         end
         run_shape(rows, cols);
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      // Anything still waiting here was never answered.
      while (found_due.size() != 0) begin
         void'(found_due.pop_front());
         flag_error("search beat never answered");
      end

      $display("Sent %0d request beats: %0d cell writes and %0d searches, %0d answered found.",
               items_sent, writes_sent, searches_sent, hits_seen);
      $display("Covered %0d random grid shapes plus empty, clipped and one-wide grids; %0d errors.",
               shape_count, mismatch_count);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
